[sv/ipc_pkg.sv]
// Package for the integer partition counter: control word layout, step
// addresses, status codes and the microprogram ROM. No dependencies.
`default_nettype none

package ipc_pkg;

  localparam int unsigned COUNT_W = 21;
  localparam int unsigned VALUE_W = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned UPC_W = 4;

  typedef logic [UPC_W-1:0] upc_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_ZERO  = 2'd1;
  localparam status_t ST_RANGE = 2'd2;

  // Step addresses of the microprogram.
  localparam upc_t UA_IDLE  = 4'd0;
  localparam upc_t UA_CHECK = 4'd1;
  localparam upc_t UA_INIT  = 4'd2;
  localparam upc_t UA_KSET  = 4'd3;
  localparam upc_t UA_READ  = 4'd4;
  localparam upc_t UA_ACC   = 4'd5;
  localparam upc_t UA_KNEXT = 4'd6;
  localparam upc_t UA_RDN   = 4'd7;
  localparam upc_t UA_EMIT  = 4'd8;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_NOT_START,
    COND_BAD,
    COND_J_NE_N,
    COND_K_NE_M
  } cond_e;

  typedef struct packed {
    logic  latch_in;  // capture the input word
    logic  check;     // classify, clamp m, j = 0, k = 1
    logic  init_wr;   // write the initial row entry at j, then j++
    logic  set_j;     // j = k
    logic  rd_pair;   // read row[j] and row[j-k]
    logic  acc_wr;    // write the saturated sum at j, then j++
    logic  k_inc;     // k++
    logic  rd_n;      // read row[n]
    logic  emit;      // present the result word
    cond_e cond;
    upc_t  target;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic bad;
    logic j_ne_n;
    logic k_ne_m;
  } flags_t;

  function automatic ctrl_t ucode_rom(input upc_t addr);
    ctrl_t cw;
    cw = '0;
    cw.cond = COND_NONE;
    cw.target = UA_IDLE;
    unique case (addr)
      UA_IDLE: begin
        cw.latch_in = 1'b1;
        cw.cond = COND_NOT_START;
        cw.target = UA_IDLE;
      end
      UA_CHECK: begin
        cw.check = 1'b1;
        cw.cond = COND_BAD;
        cw.target = UA_EMIT;
      end
      UA_INIT: begin
        cw.init_wr = 1'b1;
        cw.cond = COND_J_NE_N;
        cw.target = UA_INIT;
      end
      UA_KSET: begin
        cw.set_j = 1'b1;
      end
      UA_READ: begin
        cw.rd_pair = 1'b1;
      end
      UA_ACC: begin
        cw.acc_wr = 1'b1;
        cw.cond = COND_J_NE_N;
        cw.target = UA_READ;
      end
      UA_KNEXT: begin
        cw.k_inc = 1'b1;
        cw.cond = COND_K_NE_M;
        cw.target = UA_KSET;
      end
      UA_RDN: begin
        cw.rd_n = 1'b1;
      end
      UA_EMIT: begin
        cw.emit = 1'b1;
        cw.cond = COND_ALWAYS;
        cw.target = UA_IDLE;
      end
      default: begin
        cw.cond = COND_ALWAYS;
        cw.target = UA_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

[sv/ipc_useq.sv]
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on ipc_pkg.
`default_nettype none

module ipc_useq (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ipc_pkg::flags_t flags_i,
  output ipc_pkg::ctrl_t      ctrl_o,
  output logic                busy_o
);
  import ipc_pkg::*;

  upc_t  upc_q, upc_d;
  ctrl_t cw;
  logic  take;

  assign cw = ucode_rom(upc_q);
  assign ctrl_o = cw;
  assign busy_o = (upc_q != UA_IDLE);

  always_comb begin
    unique case (cw.cond)
      COND_NONE:      take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_NOT_START: take = !flags_i.start;
      COND_BAD:       take = flags_i.bad;
      COND_J_NE_N:    take = flags_i.j_ne_n;
      COND_K_NE_M:    take = flags_i.k_ne_m;
      default:        take = 1'b1;
    endcase
  end

  always_comb begin
    upc_d = take ? cw.target : upc_q + upc_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UA_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

`default_nettype wire

[sv/ipc_datapath.sv]
// Datapath: operand registers, row and part indexes, scratch row memory and
// saturating adder. Driven by control words from ipc_useq; depends on ipc_pkg.
`default_nettype none

module ipc_datapath #(
  parameter int unsigned MAX_N = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire ipc_pkg::ctrl_t                  ctrl_i,
  input  wire logic                            start_i,
  input  wire logic [ipc_pkg::VALUE_W-1:0]     n_value_i,
  input  wire logic [ipc_pkg::VALUE_W-1:0]     m_limit_i,
  output ipc_pkg::flags_t                      flags_o,
  output logic [ipc_pkg::COUNT_W-1:0]          count_o,
  output ipc_pkg::status_t                     status_o
);
  import ipc_pkg::*;

  localparam int unsigned DEPTH = MAX_N + 1;
  localparam int unsigned AW = $clog2(DEPTH);

  logic [VALUE_W-1:0] n_q, m_q;
  logic [AW-1:0]      j_q, j_d, k_q, k_d, mc_q, mc_d;
  status_t            status_q, status_d;
  logic               n_zero, n_over, bad;

  logic [COUNT_W-1:0] row_mem [DEPTH];
  logic [COUNT_W-1:0] rd_a_q, rd_b_q;
  logic [AW-1:0]      addr_a, addr_b;
  logic               we;
  logic [COUNT_W-1:0] wdata;
  logic [COUNT_W:0]   sum;

  assign n_zero = (n_q == '0) || (m_q == '0);
  assign n_over = (n_q > VALUE_W'(MAX_N));
  assign bad = n_zero || n_over;

  assign flags_o.start  = start_i;
  assign flags_o.bad    = bad;
  assign flags_o.j_ne_n = (j_q != n_q[AW-1:0]);
  assign flags_o.k_ne_m = (k_q != mc_q);

  always_comb begin
    j_d = j_q;
    k_d = k_q;
    mc_d = mc_q;
    status_d = status_q;
    if (ctrl_i.check) begin
      j_d = '0;
      k_d = AW'(1);
      mc_d = (m_q > n_q) ? n_q[AW-1:0] : m_q[AW-1:0];
      if (n_zero) begin
        status_d = ST_ZERO;
      end else if (n_over) begin
        status_d = ST_RANGE;
      end else begin
        status_d = ST_OK;
      end
    end
    if (ctrl_i.set_j) begin
      j_d = k_q;
    end
    if (ctrl_i.init_wr || ctrl_i.acc_wr) begin
      j_d = j_q + AW'(1);
    end
    if (ctrl_i.k_inc) begin
      k_d = k_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= ST_OK;
    end else begin
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch_in && start_i) begin
      n_q <= n_value_i;
      m_q <= m_limit_i;
    end
    j_q <= j_d;
    k_q <= k_d;
    mc_q <= mc_d;
  end

  // The sum saturates at the top of the count range.
  assign sum = {1'b0, rd_a_q} + {1'b0, rd_b_q};
  assign we = ctrl_i.init_wr || ctrl_i.acc_wr;

  always_comb begin
    if (ctrl_i.init_wr) begin
      wdata = (j_q == '0) ? COUNT_W'(1) : '0;
    end else if (sum[COUNT_W]) begin
      wdata = '1;
    end else begin
      wdata = sum[COUNT_W-1:0];
    end
  end

  assign addr_a = ctrl_i.rd_n ? n_q[AW-1:0] : j_q;
  assign addr_b = j_q - k_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      row_mem[j_q] <= wdata;
    end
    if (ctrl_i.rd_pair || ctrl_i.rd_n) begin
      rd_a_q <= row_mem[addr_a];
      rd_b_q <= row_mem[addr_b];
    end
  end

  assign count_o = (status_q == ST_OK) ? rd_a_q : '0;
  assign status_o = status_q;

endmodule

`default_nettype wire

[sv/integer_partition_counter_unit.sv]
// Top level of the integer partition counter: joins the microcode sequencer
// and the datapath. Depends on ipc_pkg, ipc_useq and ipc_datapath.
//
//   Channel  | Handshake            | Word
//   ---------+----------------------+-------------------------------------
//   command  | start in, busy out   | n_value_i[7:0], m_limit_i[7:0]
//   result   | done_o strobe        | count_o[20:0], status_o[1:0]
//
// A word is taken at a rising edge with start high and busy low. A valid
// item runs the check step, a write of each row entry up to n, and then,
// for each part size k up to m' (the part limit clamped to n), a step that
// sets j = k and a read of two entries followed by a write for each entry
// from k to n, two microprogram steps per entry; last come a read of row[n]
// and the result step. A flagged item goes from check straight to result.
// Reset clears the step counter, so the block is idle straight after reset.
// The result is shown for one cycle with done_o and cannot be held off.
`default_nettype none

module integer_partition_counter_unit #(
  parameter int unsigned MAX_N = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [ipc_pkg::VALUE_W-1:0]   n_value_i,
  input  wire logic [ipc_pkg::VALUE_W-1:0]   m_limit_i,
  output logic                               done_o,
  output logic [ipc_pkg::COUNT_W-1:0]        count_o,
  output logic [ipc_pkg::STATUS_W-1:0]       status_o
);
  import ipc_pkg::*;

  ctrl_t   ctrl;
  flags_t  flags;
  status_t status;

  // The sequencer steps through the control ROM; each control word drives
  // the datapath, and the datapath reports the loop conditions.
  ipc_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl),
    .busy_o  (busy)
  );

  ipc_datapath #(
    .MAX_N (MAX_N)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .start_i   (start),
    .n_value_i (n_value_i),
    .m_limit_i (m_limit_i),
    .flags_o   (flags),
    .count_o   (count_o),
    .status_o  (status)
  );

  // The result word is valid in the final step of the microprogram.
  assign done_o = ctrl.emit;
  assign status_o = status;

`ifndef ASSERT_OFF
  a_done_while_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result strobe outside an item");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted word did not start work");

  a_done_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy)) else $error("result strobe not single");

  a_status_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == ST_OK || status_o == ST_ZERO || status_o == ST_RANGE))
    else $error("undefined status code");
`endif

endmodule

`default_nettype wire

[verif/tb_integer_partition_counter_unit.sv]
// Self-checking testbench for integer_partition_counter_unit: command words of
// (n, m) go in, and each result word is checked against a bounded partition count.
// Depends on ipc_pkg and the integer_partition_counter_unit RTL only.
`timescale 1ns / 1ps

module tb_integer_partition_counter_unit;

  import ipc_pkg::*;

  localparam int unsigned MAX_N = 64;
  localparam int unsigned CLK_HALF = 10;
  localparam int unsigned RESET_CYCLES = 4;
  // The limit is well above the time the slowest valid word (n = m = 64)
  // keeps both channels quiet, so it only trips on a real hang.
  localparam int unsigned STALL_LIMIT = 20000;
  // This margin after the last result covers any stray strobe.
  localparam int unsigned TAIL_CYCLES = 16;
  localparam int unsigned WORDS_PER_PHASE = 40;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [COUNT_W-1:0] count_t;

  // One command word waiting to be sent. gap_pct is the chance in a hundred
  // that the sender idles in a cycle where it could present this word.
  // drain_first holds the word back until every result owed has come.
  typedef struct {
    value_t      n;
    value_t      m;
    int unsigned gap_pct;
    bit          drain_first;
  } command_word_t;

  // The result word that is due for one accepted command word.
  typedef struct {
    value_t  n;
    value_t  m;
    count_t  count;
    status_t status;
  } partition_answer_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   start = 1'b0;
  value_t n_value_i = '0;
  value_t m_limit_i = '0;
  logic   busy;
  logic   done_o;
  count_t count_o;
  status_t status_o;

  command_word_t     command_q[$];
  partition_answer_t answer_q[$];

  int results_owed = 0;
  int mismatch_count = 0;
  int words_sent = 0;
  int ok_results = 0;
  int zero_results = 0;
  int range_results = 0;
  int deepest_n = 0;
  int unsigned quiet_cycles = 0;

  integer_partition_counter_unit #(
    .MAX_N(MAX_N)
  ) i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .n_value_i(n_value_i),
    .m_limit_i(m_limit_i),
    .done_o   (done_o),
    .count_o  (count_o),
    .status_o (status_o)
  );

  always begin
    #(CLK_HALF) clk_i = 1'b1;
    #(CLK_HALF) clk_i = 1'b0;
  end

  // Counts the partitions of n into parts no larger than m. A zero operand is
  // flagged before the range check, so a zero m wins even over an n that is too
  // large. A part limit above n is clamped to n. The row is built
  // with the usual bounded-part recurrence: for each part size k, every entry j
  // picks up the ways of making j - k. Each addition saturates at the top of
  // the count field, which only matters for a larger MAX_N.
  function automatic partition_answer_t predict_partitions(input value_t n, input value_t m);
    count_t            ways[0:MAX_N];
    logic [COUNT_W:0]  sum;
    int unsigned       largest_part;
    partition_answer_t answer;
    answer.n = n;
    answer.m = m;
    answer.count = '0;
    answer.status = ST_OK;
    if (n == '0 || m == '0) begin
      answer.status = ST_ZERO;
    end else if (n > MAX_N) begin
      answer.status = ST_RANGE;
    end else begin
      largest_part = (m > n) ? n : m;
      ways[0] = count_t'(1);
      for (int unsigned j = 1; j <= n; j++) ways[j] = '0;
      for (int unsigned k = 1; k <= largest_part; k++) begin
        for (int unsigned j = k; j <= n; j++) begin
          sum = {1'b0, ways[j]} + {1'b0, ways[j-k]};
          ways[j] = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
        end
      end
      answer.count = ways[n];
    end
    return answer;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic queue_word(input int unsigned n, input int unsigned m,
                            input int unsigned gap_pct, input bit drain_first);
    command_word_t w;
    w.n = value_t'(n);
    w.m = value_t'(m);
    w.gap_pct = gap_pct;
    w.drain_first = drain_first;
    command_q.push_back(w);
  endtask

  // Sender. A word stays on the command ports with start high until the block
  // takes it. Once it is taken, the next word may follow on the very same edge,
  // so start is only written once per edge. results_owed is kept from the
  // sampled handshakes here, which makes the drain hold-off independent of the
  // order in which the two clocked blocks run.
  always @(posedge clk_i or negedge rst_ni) begin : command_driver
    logic          took_word;
    int            owed_next;
    command_word_t next_word;
    if (!rst_ni) begin
      start <= 1'b0;
      n_value_i <= '0;
      m_limit_i <= '0;
      results_owed <= 0;
    end else begin
      took_word = start && !busy;
      owed_next = results_owed + (took_word ? 1 : 0) - (done_o ? 1 : 0);
      results_owed <= owed_next;
      if (!start || took_word) begin
        if (command_q.size() != 0 && !(command_q[0].drain_first && owed_next != 0) &&
            $urandom_range(99) >= command_q[0].gap_pct) begin
          next_word = command_q.pop_front();
          start <= 1'b1;
          n_value_i <= next_word.n;
          m_limit_i <= next_word.m;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker. A result word is checked before this edge's command
  // word is predicted. The result cannot belong to a word taken on the same
  // edge, because the block shows no result while it is idle and taking a word. The watchdog
  // counts edges at which neither channel moved a word, and it is the last
  // thing in the block.
  always @(posedge clk_i) begin : result_monitor
    partition_answer_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (answer_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: count %0d status %0d",
                                    count_o, status_o));
        end else begin
          want = answer_q.pop_front();
          if (count_o !== want.count)
            report_mismatch($sformatf("n %0d m %0d: count %0d, expected %0d",
                                      want.n, want.m, count_o, want.count));
          if (status_o !== want.status)
            report_mismatch($sformatf("n %0d m %0d: status %0d, expected %0d",
                                      want.n, want.m, status_o, want.status));
          case (want.status)
            ST_OK: begin
              ok_results++;
              if (int'(want.n) > deepest_n) deepest_n = want.n;
            end
            ST_ZERO: zero_results++;
            default: range_results++;
          endcase
        end
      end
      if (start && !busy) begin
        answer_q.push_back(predict_partitions(n_value_i, m_limit_i));
        words_sent++;
      end
      if (done_o || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no word moved for %0d cycles, %0d results still owed",
                 quiet_cycles, answer_q.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned pick;
    int unsigned n;
    int unsigned m;
    int unsigned gap_pct;

    // Directed words, sent back to back. They cover zero operands, including
    // a zero m that must win over an n that is out of range, the MAX_N boundary
    // on both sides, all-ones operands, clamping of m, and the largest valid
    // word.
    queue_word(1, 1, 0, 1'b0);
    queue_word(0, 0, 0, 1'b0);
    queue_word(0, 5, 0, 1'b0);
    queue_word(5, 0, 0, 1'b0);
    queue_word(255, 0, 0, 1'b0);
    queue_word(0, 255, 0, 1'b0);
    queue_word(MAX_N + 1, 1, 0, 1'b0);
    queue_word(255, 255, 0, 1'b0);
    queue_word(128, 3, 0, 1'b0);
    queue_word(MAX_N, 1, 0, 1'b0);
    queue_word(MAX_N, MAX_N, 0, 1'b0);
    queue_word(MAX_N, 255, 0, 1'b0);
    queue_word(MAX_N, 32, 0, 1'b0);
    queue_word(MAX_N - 1, MAX_N - 2, 0, 1'b0);
    queue_word(2, 200, 0, 1'b0);
    queue_word(1, 255, 0, 1'b0);
    queue_word(10, 3, 0, 1'b0);
    queue_word(7, 7, 0, 1'b0);
    queue_word(100, 100, 0, 1'b0);
    queue_word(MAX_N + 1, MAX_N + 1, 0, 1'b0);

    // Random words in three phases: a steady stream, a sender that mostly
    // idles, and one that idles now and then. The first word of each phase
    // waits until every owed result is back, so the block also starts from
    // fully quiet. Most words are valid and small so the run stays short. A
    // tenth use n near MAX_N, and the rest are flagged words of every kind.
    for (int phase = 0; phase < 3; phase++) begin
      gap_pct = (phase == 1) ? 76 : (phase == 2) ? 12 : 0;
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        pick = $urandom_range(99);
        if (pick < 4) begin
          n = $urandom_range(255);
          m = 0;
        end else if (pick < 7) begin
          n = 0;
          m = $urandom_range(255);
        end else if (pick < 12) begin
          n = $urandom_range(255, MAX_N + 1);
          m = $urandom_range(255);
        end else if (pick < 22) begin
          n = $urandom_range(MAX_N, 48);
          m = $urandom_range(MAX_N, 1);
        end else if (pick < 40) begin
          n = $urandom_range(40, 1);
          m = $urandom_range(255, 1);
        end else begin
          n = $urandom_range(32, 1);
          m = $urandom_range(n, 1);
        end
        queue_word(n, m, gap_pct, i == 0);
      end
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (command_q.size() != 0 || start || results_owed != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (answer_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", answer_q.size()));

    $display("Summary: %0d words sent, %0d valid results (largest n %0d), %0d zero-flagged,",
             words_sent, ok_results, deepest_n, zero_results);
    $display("         %0d out of range, %0d mismatches; sender idling 0, 76 and 12 in 100.",
             range_results, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/ipc_pkg.sv
sv/ipc_useq.sv
sv/ipc_datapath.sv
sv/integer_partition_counter_unit.sv
verif/tb_integer_partition_counter_unit.sv
